// ----- hdl/erm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erm_pkg
// Shared types, constants and helpers of the Euler rotation matrix block.
// ----------------------------------------------------------------------------
package erm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int STEPS      = 30;
    localparam int MIX_STAGES = 4;
    localparam int DEPTH      = STEPS + MIX_STAGES;
    localparam int XW         = 36;
    localparam int ZW         = 34;
    localparam int SW         = 5;
    localparam int EW         = 16;
    localparam int TW         = 34;

    localparam logic signed [XW-1:0] GAIN_INV = XW'(64'd2608131496);
    localparam logic signed [EW-1:0] UNIT     = EW'(1 << FRAC_BITS);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           q;
    } erm_vec_t;

    typedef struct packed {
        logic signed [EW-1:0] m00;
        logic signed [EW-1:0] m10;
        logic signed [EW-1:0] m20;
        logic signed [EW-1:0] m01;
        logic signed [EW-1:0] m11;
        logic signed [EW-1:0] m21;
        logic signed [EW-1:0] m02;
        logic signed [EW-1:0] m12;
        logic signed [EW-1:0] m22;
    } erm_mat_t;

    function automatic logic [29:0] atan_val(input logic [SW-1:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [EW-1:0] sat_unit(input logic signed [XW-1:0] v);
        logic signed [EW-1:0] r;
        if (v > XW'(UNIT))
            r = UNIT;
        else if (v < -XW'(UNIT))
            r = -UNIT;
        else
            r = EW'(v);
        return r;
    endfunction

    function automatic logic signed [TW-1:0] rnd_frac(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] t;
        t = v + TW'(1 << (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/erm_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erm_cell
// One CORDIC rotation step; registers the rotated vector for the next cell.
// ----------------------------------------------------------------------------
module erm_cell (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [erm_pkg::SW-1:0]     step,
    input  wire erm_pkg::erm_vec_t          vin,
    output erm_pkg::erm_vec_t               vout
);

    erm_pkg::erm_vec_t              vec_reg;
    erm_pkg::erm_vec_t              vec_next;
    logic signed [erm_pkg::XW-1:0]  sh_x;
    logic signed [erm_pkg::XW-1:0]  sh_y;
    logic signed [erm_pkg::ZW-1:0]  ang;

    always_comb
    begin
        sh_x       = vin.x >>> step;
        sh_y       = vin.y >>> step;
        ang        = erm_pkg::ZW'(erm_pkg::atan_val(step));
        vec_next.q = vin.q;
        if (!vin.z[erm_pkg::ZW-1])
        begin
            vec_next.x = vin.x - sh_y;
            vec_next.y = vin.y + sh_x;
            vec_next.z = vin.z - ang;
        end
        else
        begin
            vec_next.x = vin.x + sh_y;
            vec_next.y = vin.y - sh_x;
            vec_next.z = vin.z + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign vout = vec_reg;

endmodule
`default_nettype wire

// ----- hdl/erm_mix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erm_mix
// Fold quadrants, round sine and cosine, then form the nine matrix entries.
// ----------------------------------------------------------------------------
module erm_mix (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire erm_pkg::erm_vec_t  va,
    input  wire erm_pkg::erm_vec_t  vb,
    input  wire erm_pkg::erm_vec_t  vc,
    output erm_pkg::erm_mat_t       mat
);

    localparam int EW = erm_pkg::EW;
    localparam int TW = erm_pkg::TW;
    localparam int XW = erm_pkg::XW;
    localparam int RS = 32 - erm_pkg::FRAC_BITS;

    typedef logic signed [EW-1:0] ent_t;
    typedef logic signed [TW-1:0] wide_t;

    // fold
    ent_t sa_reg, ca_reg, sb_reg, cb_reg, sc_reg, cc_reg;
    ent_t sa_next, ca_next, sb_next, cb_next, sc_next, cc_next;
    // products
    wide_t p00_reg, p10_reg, p21_reg, p22_reg;
    wide_t q01_reg, q11_reg, q02_reg, q12_reg;
    ent_t  sa2_reg, ca2_reg, sb2_reg, sc2_reg, cc2_reg;
    // sums
    ent_t  m00_reg, m10_reg, m20_reg, m21_reg, m22_reg;
    wide_t t01_reg, t11_reg, t02_reg, t12_reg;
    erm_pkg::erm_mat_t mat_reg;
    erm_pkg::erm_mat_t mat_next;

    function automatic void fold(input erm_pkg::erm_vec_t v,
                                 output ent_t s, output ent_t c);
        logic signed [XW-1:0] rx;
        logic signed [XW-1:0] ry;
        ent_t cr;
        ent_t sr;
        rx = (v.x + XW'(64'sd1 << (RS - 1))) >>> RS;
        ry = (v.y + XW'(64'sd1 << (RS - 1))) >>> RS;
        cr = erm_pkg::sat_unit(rx);
        sr = erm_pkg::sat_unit(ry);
        case (v.q)
            2'd0:    begin c = cr;  s = sr;  end
            2'd1:    begin c = -sr; s = cr;  end
            2'd2:    begin c = -cr; s = -sr; end
            default: begin c = sr;  s = -cr; end
        endcase
    endfunction

    function automatic ent_t sat_w(input wide_t v);
        return erm_pkg::sat_unit(XW'(v));
    endfunction

    always_comb
    begin
        fold(va, sa_next, ca_next);
        fold(vb, sb_next, cb_next);
        fold(vc, sc_next, cc_next);
    end

    always_comb
    begin
        mat_next.m00 = m00_reg;
        mat_next.m10 = m10_reg;
        mat_next.m20 = m20_reg;
        mat_next.m21 = m21_reg;
        mat_next.m22 = m22_reg;
        mat_next.m01 = sat_w(erm_pkg::rnd_frac(t01_reg));
        mat_next.m11 = sat_w(erm_pkg::rnd_frac(t11_reg));
        mat_next.m02 = sat_w(erm_pkg::rnd_frac(t02_reg));
        mat_next.m12 = sat_w(erm_pkg::rnd_frac(t12_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg  <= sa_next;
            ca_reg  <= ca_next;
            sb_reg  <= sb_next;
            cb_reg  <= cb_next;
            sc_reg  <= sc_next;
            cc_reg  <= cc_next;

            p00_reg <= TW'(cb_reg) * TW'(cc_reg);
            p10_reg <= TW'(-cb_reg) * TW'(sc_reg);
            p21_reg <= TW'(-sa_reg) * TW'(cb_reg);
            p22_reg <= TW'(ca_reg) * TW'(cb_reg);
            q01_reg <= TW'(sa_reg) * TW'(sb_reg);
            q11_reg <= TW'(-sa_reg) * TW'(sb_reg);
            q02_reg <= TW'(-ca_reg) * TW'(sb_reg);
            q12_reg <= TW'(ca_reg) * TW'(sb_reg);
            sa2_reg <= sa_reg;
            ca2_reg <= ca_reg;
            sb2_reg <= sb_reg;
            sc2_reg <= sc_reg;
            cc2_reg <= cc_reg;

            m00_reg <= sat_w(erm_pkg::rnd_frac(p00_reg));
            m10_reg <= sat_w(erm_pkg::rnd_frac(p10_reg));
            m21_reg <= sat_w(erm_pkg::rnd_frac(p21_reg));
            m22_reg <= sat_w(erm_pkg::rnd_frac(p22_reg));
            m20_reg <= sb2_reg;
            t01_reg <= erm_pkg::rnd_frac(q01_reg) * TW'(cc2_reg)
                     + TW'(ca2_reg) * TW'(sc2_reg);
            t11_reg <= erm_pkg::rnd_frac(q11_reg) * TW'(sc2_reg)
                     + TW'(ca2_reg) * TW'(cc2_reg);
            t02_reg <= erm_pkg::rnd_frac(q02_reg) * TW'(cc2_reg)
                     + TW'(sa2_reg) * TW'(sc2_reg);
            t12_reg <= erm_pkg::rnd_frac(q12_reg) * TW'(sc2_reg)
                     + TW'(sa2_reg) * TW'(cc2_reg);

            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule
`default_nettype wire

// ----- hdl/euler_rotation_matrix.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// euler_rotation_matrix
// Three Euler angles and a translation in; XYZ rotation matrix and
// translation out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: angle_a/b/c (phase, 65536 = one turn) and move_x/y/z
//   (Q16.16), taken when in_valid is high and in_stall low.
//   Output beat: m00..m22 (Q1.14, saturated to +-1.0) and out_x/y/z,
//   delivered when out_valid is high and out_stall low.
//   Stages: 30 CORDIC cells, then fold, product, sum and output
//   stages. Throughput: one beat per cycle while the pipe is not stalled.
//   The three sines and cosines run in three parallel rows of 30 cells.
//   Each cell does one rotation step and passes its vector on whenever en is high.
//   The whole pipe advances whenever the output register is empty or being
//   taken; with out_stall high and a beat waiting, in_stall rises and all
//   stages hold.
//   Reset clears every valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_rotation_matrix (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [15:0]        angle_a,
    input  wire logic [15:0]        angle_b,
    input  wire logic [15:0]        angle_c,
    input  wire logic signed [31:0] move_x,
    input  wire logic signed [31:0] move_y,
    input  wire logic signed [31:0] move_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      m00,
    output logic signed [15:0]      m10,
    output logic signed [15:0]      m20,
    output logic signed [15:0]      m01,
    output logic signed [15:0]      m11,
    output logic signed [15:0]      m21,
    output logic signed [15:0]      m02,
    output logic signed [15:0]      m12,
    output logic signed [15:0]      m22,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z
);

    localparam int STEPS = erm_pkg::STEPS;
    localparam int DEPTH = erm_pkg::DEPTH;
    localparam int AB    = erm_pkg::ANGLE_BITS;

    logic                    en;
    logic [DEPTH-1:0]        vld_reg;
    logic [95:0]             mv_reg [DEPTH];
    logic [15:0]             ang    [3];
    erm_pkg::erm_vec_t       row    [3][STEPS+1];
    erm_pkg::erm_mat_t       mat;

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;
    assign ang[0]   = angle_a;
    assign ang[1]   = angle_b;
    assign ang[2]   = angle_c;

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        logic [31:0] phase;
        logic [1:0]  quad;
        logic [31:0] resid;

        assign phase = {ang[r][AB-1:0], {(32-AB){1'b0}}};
        assign quad  = 2'((phase + 32'h2000_0000) >> 30);
        assign resid = phase - {quad, 30'd0};

        assign row[r][0].x = erm_pkg::GAIN_INV;
        assign row[r][0].y = '0;
        assign row[r][0].z = erm_pkg::ZW'($signed(resid));
        assign row[r][0].q = quad;

        for (genvar k = 0; k < STEPS; k++)
        begin : g_cell
            erm_cell u_cell (
                .clk  (clk),
                .en   (en),
                .step (erm_pkg::SW'(k)),
                .vin  (row[r][k]),
                .vout (row[r][k+1])
            );
        end
    end

    erm_mix u_mix (
        .clk (clk),
        .en  (en),
        .va  (row[0][STEPS]),
        .vb  (row[1][STEPS]),
        .vc  (row[2][STEPS]),
        .mat (mat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mv_reg[0] <= {move_x, move_y, move_z};
            for (int i = 1; i < DEPTH; i++)
                mv_reg[i] <= mv_reg[i-1];
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign m00   = mat.m00;
    assign m10   = mat.m10;
    assign m20   = mat.m20;
    assign m01   = mat.m01;
    assign m11   = mat.m11;
    assign m21   = mat.m21;
    assign m02   = mat.m02;
    assign m12   = mat.m12;
    assign m22   = mat.m22;
    assign out_x = mv_reg[DEPTH-1][95:64];
    assign out_y = mv_reg[DEPTH-1][63:32];
    assign out_z = mv_reg[DEPTH-1][31:0];

    a_stall_only_on_backpressure: assert property (
        @(posedge clk) disable iff (!rst_n) in_stall == (out_valid && out_stall))
        else $error("input stall without a held output beat");

    a_pipe_holds: assert property (
        @(posedge clk) disable iff (!rst_n) in_stall |=> $stable(vld_reg))
        else $error("pipe moved while stalled");

    a_m00_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (m00 <= 16'sd16384 && m00 >= -16'sd16384))
        else $error("m00 beyond unit range");

    a_m11_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (m11 <= 16'sd16384 && m11 >= -16'sd16384))
        else $error("m11 beyond unit range");

endmodule
`default_nettype wire
